// ----- rtl/keyed_frame_crc16_coder_defines.svh -----
// Assertion macros for the keyed frame CRC-16 coder.
// Used by the top level only; needs nothing else.
`ifndef KEYED_FRAME_CRC16_CODER_DEFINES_SVH
`define KEYED_FRAME_CRC16_CODER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define KFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define KFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kfc_pkg.sv -----
// Shared types, codes and the CRC-16 byte update for the keyed frame coder.
// No dependencies; imported by every module of the block.
package kfc_pkg;

  // CRC-16/XMODEM generator
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Shortest frame: one payload byte, tag, two CRC bytes
  localparam logic [7:0] MIN_FRAME   = 8'd4;
  localparam logic [7:0] TRAILER_LEN = 8'd3;

  // Register reset values
  localparam logic [7:0] FRAME_LEN_RST = 8'd16;
  localparam logic [7:0] KEY_LEN_RST   = 8'd8;

  // Result queue: holds a full trailer burst plus headroom
  localparam int OUT_DEPTH   = 8;
  localparam int PTR_W       = $clog2(OUT_DEPTH);
  localparam int MAX_PUSH    = 4;
  localparam int PUSH_W      = $clog2(MAX_PUSH + 1);

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE      = 2'd0;
  localparam logic [1:0] CFG_CHANNEL   = 2'd1;
  localparam logic [1:0] CFG_FRAME_LEN = 2'd2;
  localparam logic [1:0] CFG_KEY_LEN   = 2'd3;

  // Mode codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_KEY_MISMATCH = 2'd1,
    STATUS_CRC_ERROR    = 2'd2
  } status_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] channel_number;
    logic [7:0] frame_length;
    logic [7:0] key_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] expected_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } result_t;

  // Results made by one item, slot 0 first
  typedef struct packed {
    logic [PUSH_W-1:0]         num;
    result_t [MAX_PUSH-1:0]    res;
  } push_t;

  // Queue fill level, seen by the input stage
  typedef struct packed {
    logic [PTR_W:0] count;
  } fifo_stat_t;

  // One byte through the CRC, MSB first; an 8-step XOR network
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in;
    for (int k = 0; k < 8; k++) begin
      if (c[15] ^ b[7-k]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/keyed_frame_crc16_coder.sv -----
// Top level of the keyed frame CRC-16 coder: config registers, input stage.
// Depends on kfc_pkg, kfc_core, kfc_out_fifo and the assertion macro header.
//
// channel  handshake              payload
// item     item_valid/item_stall  data_byte, expected_byte
// result   result_valid/stall     out_byte, status, last
// cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// An item is registered on accept and processed once the queue has room: one item per cycle while it does not back up.
// Encode gives one result per payload byte, four on the last (echo, tag, CRC hi, lo);
// decode gives one status result at frame end. Queue of 8 results: the input stage
// moves on only while four slots are free, so output stalls back up to item_stall.
// Synchronous reset clears the control state; no clearing pass.
`include "keyed_frame_crc16_coder_defines.svh"
module keyed_frame_crc16_coder import kfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] data_byte,
  input  logic [7:0] expected_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic [1:0] status,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t       cfg;
  item_t      item;
  logic       item_full, item_full_next;
  logic       go;
  logic       take;
  push_t      push;
  result_t    head;
  fifo_stat_t stat;

  // Configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_ENCODE;
      cfg.channel_number <= '0;
      cfg.frame_length   <= FRAME_LEN_RST;
      cfg.key_length     <= KEY_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:      cfg.mode           <= cfg_data[0];
        CFG_CHANNEL:   cfg.channel_number <= cfg_data;
        CFG_FRAME_LEN: cfg.frame_length   <= cfg_data;
        CFG_KEY_LEN:   cfg.key_length     <= cfg_data;
        default:       cfg.mode           <= cfg.mode;
      endcase
    end
  end

  // Input stage: advances while the queue has room for a full burst
  assign go             = item_full && (stat.count <= (PTR_W+1)'(OUT_DEPTH - MAX_PUSH));
  assign item_stall     = item_full && !go;
  assign take           = item_valid && !item_stall;
  assign item_full_next = take || (item_full && !go);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else begin
      item_full <= item_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.data_byte     <= data_byte;
      item.expected_byte <= expected_byte;
    end
  end

  kfc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .go   (go),
    .push (push)
  );

  kfc_out_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .head         (head),
    .stat         (stat)
  );

  assign out_byte = head.data;
  assign status   = 2'(head.status);
  assign last     = head.last;

  // Checks
  `KFC_ASSERT_NOW(a_fifo_bound, clk, rst, 1'b1, stat.count <= (PTR_W+1)'(OUT_DEPTH), "result queue overflow")
  `KFC_ASSERT_NOW(a_stall_only_full, clk, rst, item_stall, item_full, "stall with empty input stage")
  `KFC_ASSERT_NOW(a_burst_ends_frame, clk, rst, push.num == PUSH_W'(MAX_PUSH), push.res[MAX_PUSH-1].last, "trailer burst without frame end")
  `KFC_ASSERT_NEXT(a_push_lands, clk, rst, push.num != '0, result_valid, "pushed result not visible")

endmodule

// ----- rtl/kfc_core.sv -----
// Frame state and per-item compute for the keyed frame coder.
// Depends on kfc_pkg; feeds the result queue kfc_out_fifo.
module kfc_core import kfc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  item_t item,
  input  logic  go,
  output push_t push
);

  logic [7:0]  position, position_next;
  logic [7:0]  byte_sum, byte_sum_next;
  logic [15:0] crc_value, crc_value_next;
  logic        key_mismatch, key_mismatch_next;
  logic [7:0]  tag_seen, tag_seen_next;

  logic [7:0]  fl;
  logic [7:0]  payload;
  logic [8:0]  pos_inc;
  logic [7:0]  sum1;
  logic [15:0] crc1;
  logic [7:0]  tag;
  logic [15:0] crc2;
  logic        km;
  logic [7:0]  dec_sum;
  logic [7:0]  dec_tag;
  status_t     st;

  // Combinational terms for encode and decode
  always_comb begin
    fl      = (cfg.frame_length < MIN_FRAME) ? MIN_FRAME : cfg.frame_length;
    payload = fl - TRAILER_LEN;
    pos_inc = {1'b0, position} + 9'd1;
    sum1    = byte_sum + item.data_byte;
    crc1    = crc_byte(crc_value, item.data_byte);
    tag     = sum1 + cfg.channel_number;
    crc2    = crc_byte(crc1, tag);
    km      = key_mismatch |
              ((position < cfg.key_length) && (item.data_byte != item.expected_byte));
    dec_sum = (position < payload) ? sum1 : byte_sum;
    dec_tag = (position == payload) ? item.data_byte : tag_seen;
    if (km) begin
      st = STATUS_KEY_MISMATCH;
    end else if (crc1 != 16'd0) begin
      st = STATUS_CRC_ERROR;
    end else begin
      st = STATUS_OK;
    end
  end

  // Next state and results for the item in the input register
  always_comb begin
    position_next     = position;
    byte_sum_next     = byte_sum;
    crc_value_next    = crc_value;
    key_mismatch_next = key_mismatch;
    tag_seen_next     = tag_seen;
    push              = '0;
    for (int k = 0; k < MAX_PUSH; k++) begin
      push.res[k].status = STATUS_OK;
    end
    if (cfg.mode == MODE_ENCODE) begin
      push.res[0].data = item.data_byte;
      if (pos_inc < {1'b0, payload}) begin
        push.num       = PUSH_W'(1);
        position_next  = pos_inc[7:0];
        byte_sum_next  = sum1;
        crc_value_next = crc1;
      end else begin
        // last payload byte: echo, tag, CRC high, CRC low
        push.num          = PUSH_W'(MAX_PUSH);
        push.res[1].data  = tag;
        push.res[2].data  = crc2[15:8];
        push.res[3].data  = crc2[7:0];
        push.res[3].last  = 1'b1;
        position_next     = '0;
        byte_sum_next     = '0;
        crc_value_next    = '0;
        key_mismatch_next = 1'b0;
        tag_seen_next     = '0;
      end
    end else begin
      if (pos_inc < {1'b0, fl}) begin
        position_next     = pos_inc[7:0];
        byte_sum_next     = dec_sum;
        crc_value_next    = crc1;
        key_mismatch_next = km;
        tag_seen_next     = dec_tag;
      end else begin
        // frame end: one status result with the recovered channel, zero unless OK
        push.num           = PUSH_W'(1);
        push.res[0].status = st;
        push.res[0].data   = (st == STATUS_OK) ? (dec_tag - dec_sum) : 8'd0;
        push.res[0].last   = 1'b1;
        position_next      = '0;
        byte_sum_next      = '0;
        crc_value_next     = '0;
        key_mismatch_next  = 1'b0;
        tag_seen_next      = '0;
      end
    end
    if (!go) begin
      push.num = '0;
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      byte_sum     <= '0;
      crc_value    <= '0;
      key_mismatch <= 1'b0;
      tag_seen     <= '0;
    end else if (go) begin
      position     <= position_next;
      byte_sum     <= byte_sum_next;
      crc_value    <= crc_value_next;
      key_mismatch <= key_mismatch_next;
      tag_seen     <= tag_seen_next;
    end
  end

endmodule

// ----- rtl/kfc_out_fifo.sv -----
// Result queue: takes up to four results per cycle, gives one per cycle while result_stall is low.
// Depends on kfc_pkg; fed by kfc_core.
module kfc_out_fifo import kfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  input  logic       result_stall,
  output logic       result_valid,
  output result_t    head,
  output fifo_stat_t stat
);

  result_t [OUT_DEPTH-1:0] entries;
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [PTR_W:0]   count, count_next;
  logic             pop;

  assign result_valid = (count != '0);
  assign head         = entries[rd_ptr];
  assign pop          = result_valid && !result_stall;
  assign stat.count   = count;

  // Pointer and fill arithmetic
  always_comb begin
    wr_ptr_next = wr_ptr + PTR_W'(push.num);
    rd_ptr_next = rd_ptr + PTR_W'(pop);
    count_next  = count + (PTR_W+1)'(push.num) - (PTR_W+1)'(pop);
  end

  // Entry writes of the pushed results; the input stage keeps them to free slots
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_PUSH; k++) begin
      if (PUSH_W'(k) < push.num) begin
        entries[wr_ptr + PTR_W'(k)] <= push.res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule
